// ===== rtl/ksos_pkg.sv =====
// Package for the k-th smallest order statistic unit.
// Holds widths, operation and status codes and the cell interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksos_pkg;

  localparam int unsigned KSOS_CAPACITY = 256;
  localparam int unsigned KSOS_DW       = 32;
  localparam int unsigned KSOS_RANK_W   = 16;
  localparam int unsigned KSOS_MODE_W   = 2;
  localparam int unsigned KSOS_STAT_W   = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned KSOS_IN_W  = 56;
  localparam int unsigned KSOS_OUT_W = 40;

  typedef enum logic [KSOS_MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [KSOS_STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic clear;
    logic write;
  } cell_ctrl_t;

  // Flags that a cell hands to its right-hand neighbour and to the top level.
  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/ksos_cell.sv =====
// One cell of the sorted chain: holds a single value and its occupied flag.
// Depends on ksos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksos_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ksos_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [ksos_pkg::KSOS_DW-1:0] value_i,
  input  logic signed [ksos_pkg::KSOS_DW-1:0] left_value_i,
  input  ksos_pkg::cell_flags_t               left_flags_i,
  output logic signed [ksos_pkg::KSOS_DW-1:0] value_o,
  output ksos_pkg::cell_flags_t               flags_o
);
  import ksos_pkg::*;

  logic                      valid_q, valid_d;
  logic signed [KSOS_DW-1:0] val_q, val_d;
  logic                      lt;

  assign lt = valid_q && (val_q < value_i);

  assign flags_o.valid = valid_q;
  assign flags_o.lt    = lt;
  assign flags_o.eq    = valid_q && (val_q == value_i);
  assign value_o       = val_q;

  // The cells below the insertion point keep their value. The first cell
  // not below takes the new value and every cell after it takes its left
  // neighbour's contents, so the whole tail moves by one place at once.
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.write && !lt) begin
      if (left_flags_i.lt) begin
        valid_d = 1'b1;
        val_d   = value_i;
      end else begin
        valid_d = left_flags_i.valid;
        val_d   = left_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== rtl/kth_smallest_of_set_unit.sv =====
// The result of an item is registered and shows on the output stream in the
// cycle after its transfer is accepted. Throughput: one item per cycle while
// the output is taken; the output register holds one result and the input
// stalls only while it waits. The chain does every operation combinationally.
// Reset is asynchronous and active low: it empties the set and the output.
`timescale 1ns / 1ps
`default_nettype none

module kth_smallest_of_set_unit #(
  parameter int unsigned CAPACITY = ksos_pkg::KSOS_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // mode [1:0], value [33:2], rank [49:34], zeros above
  input  logic [ksos_pkg::KSOS_IN_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // result_value [31:0], found [32], status [34:33], zeros above
  output logic [ksos_pkg::KSOS_OUT_W-1:0]   m_axis_tdata_o
);
  import ksos_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic                      in_xfer;
  logic [KSOS_MODE_W-1:0]    mode;
  logic signed [KSOS_DW-1:0] value;
  logic [KSOS_RANK_W-1:0]    rank;
  logic [KSOS_RANK_W-1:0]    rank_m1;

  logic signed [KSOS_DW-1:0] cell_val [CAPACITY];
  cell_flags_t               cell_flags [CAPACITY];
  cell_ctrl_t                ctrl;

  logic [CW-1:0]             count_q, count_d;
  logic                      dup, full, in_range;
  logic signed [KSOS_DW-1:0] rd_val;

  logic                      out_valid_q;
  logic signed [KSOS_DW-1:0] res_val_q, res_val_d;
  logic                      found_q, found_d;
  status_e                   status_q, status_d;

  assign mode    = s_axis_tdata_i[1:0];
  assign value   = s_axis_tdata_i[33:2];
  assign rank    = s_axis_tdata_i[49:34];
  assign rank_m1 = rank - KSOS_RANK_W'(1);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Since the set holds distinct values, at most one cell can match.
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      dup = dup | cell_flags[i].eq;
    end
  end

  assign full     = cell_flags[CAPACITY-1].valid;
  assign in_range = (rank != '0) && (rank <= KSOS_RANK_W'(count_q));

  // Select the addressed cell by an AND-OR over the row.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rank_m1[IW-1:0] == IW'(i)) begin
        rd_val = rd_val | cell_val[i];
      end
    end
  end

  always_comb begin
    ctrl.clear = 1'b0;
    ctrl.write = 1'b0;
    count_d    = count_q;
    res_val_d  = '1;
    found_d    = 1'b0;
    status_d   = ST_DONE;
    case (mode)
      MODE_CLEAR: begin
        ctrl.clear = in_xfer;
        if (in_xfer) begin
          count_d = '0;
        end
      end
      MODE_INSERT: begin
        if (dup) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.write = in_xfer;
          if (in_xfer) begin
            count_d = count_q + CW'(1);
          end
        end
      end
      MODE_QUERY: begin
        if (in_range) begin
          res_val_d = rd_val;
          found_d   = 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [KSOS_DW-1:0] left_val;
    cell_flags_t               left_flags;

    if (g == 0) begin : g_head
      assign left_val   = value;
      assign left_flags = '{valid: 1'b1, lt: 1'b1, eq: 1'b0};
    end else begin : g_body
      assign left_val   = cell_val[g-1];
      assign left_flags = cell_flags[g-1];
    end

    ksos_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .value_i      (value),
      .left_value_i (left_val),
      .left_flags_i (left_flags),
      .value_o      (cell_val[g]),
      .flags_o      (cell_flags[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_val_q <= res_val_d;
      found_q   <= found_d;
      status_q  <= status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, status_q, found_q, res_val_q};

endmodule

`default_nettype wire

// ===== rtl/ksos_checker.sv =====
// Port-level checker for the k-th smallest order statistic unit, bound to
// the top level. Depends on ksos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksos_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [ksos_pkg::KSOS_IN_W-1:0]  s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ksos_pkg::KSOS_OUT_W-1:0] m_axis_tdata_o
);
  import ksos_pkg::*;

  // Every accepted transfer gives a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("no result after an accepted transfer");

  // A successful query always reports status done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[34:33] == ST_DONE)
    else $error("found result with a non-done status");

  // Without a hit the value field carries minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[32] |-> m_axis_tdata_o[31:0] == '1)
    else $error("miss result without minus one");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind kth_smallest_of_set_unit ksos_checker u_ksos_checker (.*);

`default_nettype wire
